@@ design/wcfb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wcfb_pkg
// Shared types and constants for the windowed cursor frame buffer.
// ----------------------------------------------------------------------------
package wcfb_pkg;

    localparam int DEF_PANEL_COLUMNS = 128;
    localparam int DEF_PANEL_PAGES   = 8;
    localparam int ROWS_PER_PAGE     = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_MODE  = 3'd4;

    localparam logic [7:0] WIN_WIDTH_RST  = 8'd128;
    localparam logic [6:0] WIN_HEIGHT_RST = 7'd64;

    // request codes
    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // scan modes
    localparam logic [2:0] SCAN_XP_YP = 3'd0;
    localparam logic [2:0] SCAN_XM_YM = 3'd1;
    localparam logic [2:0] SCAN_XM_YP = 3'd2;
    localparam logic [2:0] SCAN_XP_YM = 3'd3;
    localparam logic [2:0] SCAN_XP    = 3'd4;
    localparam logic [2:0] SCAN_YP    = 3'd5;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       pixel_in;
    } req_t;

    typedef struct packed {
        logic       pixel_out;
        logic       written;
        logic [7:0] cur_x;
        logic [7:0] cur_y;
    } res_t;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic commit;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } ctrl_sts_t;

endpackage
`default_nettype wire

@@ design/windowed_cursor_frame_buffer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_cursor_frame_buffer
// Monochrome page frame buffer with a write window and auto-incrementing
// cursor.
//
// Usage:
//   Request channel: req is taken at a rising edge with start high and busy
//   low. Configuration: cfg_we, cfg_index, cfg_data write one register per
//   edge (window x, y, width, height, scan mode); write only while idle.
//   Result channel: done is high for one cycle with result valid; there is
//   no back-pressure, so the receiver must take it then.
//   Item flow: an accepted item passes through the lookup and commit
//   states for the byte read-modify-write of the store, and done is
//   registered at the end of commit. The next item can be taken in the
//   cycle that done is shown.
//   Reset: busy stays high while all PANEL_PAGES * PANEL_COLUMNS bytes of
//   the store (1024 at the defaults) are cleared one byte per cycle;
//   configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
module windowed_cursor_frame_buffer
    import wcfb_pkg::*;
#(
    parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
    parameter int PANEL_PAGES   = DEF_PANEL_PAGES
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire req_t                   req,
    output logic                        done,
    output res_t                        result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    wcfb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    wcfb_datapath #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .PANEL_PAGES   (PANEL_PAGES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("item result missing");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

endmodule
`default_nettype wire

@@ design/wcfb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wcfb_ctrl
// Sequencer: clearing pass after reset, then lookup and commit per item.
// ----------------------------------------------------------------------------
module wcfb_ctrl
    import wcfb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      cmd,
    output logic           busy
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cmd.accept = (state_reg == ST_IDLE) && start;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.commit = (state_reg == ST_COMMIT);
    assign cmd.clear  = (state_reg == ST_CLEAR);

    a_commit_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> cmd.commit)
        else $error("commit did not follow lookup");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !busy)
        else $error("item accepted while busy");

    a_clear_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clear && sts.clear_last) |=> !busy)
        else $error("clearing pass did not end in idle");

endmodule
`default_nettype wire

@@ design/wcfb_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wcfb_datapath
// Page store, window and cursor registers, byte read-modify-write and
// cursor advance.
// ----------------------------------------------------------------------------
module wcfb_datapath
    import wcfb_pkg::*;
#(
    parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
    parameter int PANEL_PAGES   = DEF_PANEL_PAGES
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ctrl_cmd_t              cmd,
    output ctrl_sts_t                   sts,
    input  wire req_t                   req,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        done,
    output res_t                        result
);

    localparam int STORE_DEPTH = PANEL_PAGES * PANEL_COLUMNS;
    localparam int PANEL_ROWS  = PANEL_PAGES * ROWS_PER_PAGE;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int SUM_W       = AW + 9;

    localparam logic [8:0]    COLS_LIM  = 9'(PANEL_COLUMNS);
    localparam logic [8:0]    ROWS_LIM  = 9'(PANEL_ROWS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

    logic [7:0] mem [STORE_DEPTH];

    logic [6:0] win_x_reg;
    logic [5:0] win_y_reg;
    logic [7:0] win_width_reg;
    logic [6:0] win_height_reg;
    logic [2:0] scan_mode_reg;

    logic [7:0]    cursor_col_reg;
    logic [7:0]    cursor_row_reg;
    logic [AW-1:0] clr_cnt_reg;
    req_t          req_reg;
    logic [7:0]    rdata_reg;
    logic          done_reg;
    res_t          result_reg;

    logic [7:0]    look_x;
    logic [7:0]    look_y;
    logic [SUM_W-1:0] addr_sum;
    logic [AW-1:0] addr;
    logic          on_panel;
    logic          in_window;
    logic [7:0]    bit_mask;
    logic          land;
    logic [7:0]    wdata;

    logic [8:0] x_end;
    logic [8:0] y_end;
    logic [8:0] x_inc;
    logic [8:0] y_inc;
    logic [7:0] x_fwd;
    logic [7:0] x_back;
    logic [7:0] y_fwd;
    logic [7:0] y_back;
    logic       x_wrap_up;
    logic       x_wrap_dn;
    logic [7:0] adv_x;
    logic [7:0] adv_y;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_reg      <= '0;
            win_y_reg      <= '0;
            win_width_reg  <= WIN_WIDTH_RST;
            win_height_reg <= WIN_HEIGHT_RST;
            scan_mode_reg  <= SCAN_XP_YP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIN_X:      win_x_reg      <= cfg_data[6:0];
                REG_WIN_Y:      win_y_reg      <= cfg_data[5:0];
                REG_WIN_WIDTH:  win_width_reg  <= cfg_data;
                REG_WIN_HEIGHT: win_height_reg <= cfg_data[6:0];
                REG_SCAN_MODE:  scan_mode_reg  <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // ---- addressing ----
    always_comb
    begin
        look_x    = (req_reg.req_type == REQ_WRITE) ? cursor_col_reg : req_reg.pos_x;
        look_y    = (req_reg.req_type == REQ_WRITE) ? cursor_row_reg : req_reg.pos_y;
        addr_sum  = SUM_W'(look_y[7:3]) * SUM_W'(PANEL_COLUMNS) + SUM_W'(look_x);
        addr      = addr_sum[AW-1:0];
        on_panel  = ({1'b0, look_x} < COLS_LIM) && ({1'b0, look_y} < ROWS_LIM);
        x_end     = 9'(win_x_reg) + 9'(win_width_reg);
        y_end     = 9'(win_y_reg) + 9'(win_height_reg);
        in_window = ({1'b0, look_x} >= 9'(win_x_reg)) && ({1'b0, look_x} < x_end) &&
                    ({1'b0, look_y} >= 9'(win_y_reg)) && ({1'b0, look_y} < y_end);
        bit_mask  = 8'd1 << look_y[2:0];
        land      = cmd.commit && (req_reg.req_type == REQ_WRITE) && in_window && on_panel;
        wdata     = (rdata_reg & ~bit_mask) | (req_reg.pixel_in ? bit_mask : 8'd0);
    end

    // ---- cursor advance ----
    always_comb
    begin
        x_inc     = 9'(cursor_col_reg) + 9'd1;
        y_inc     = 9'(cursor_row_reg) + 9'd1;
        x_wrap_up = (x_inc >= x_end);
        x_wrap_dn = (cursor_col_reg <= 8'(win_x_reg));
        x_fwd     = x_wrap_up ? 8'(win_x_reg) : x_inc[7:0];
        x_back    = x_wrap_dn ? (x_end[7:0] - 8'd1) : (cursor_col_reg - 8'd1);
        y_fwd     = (y_inc >= y_end) ? 8'(win_y_reg) : y_inc[7:0];
        y_back    = (cursor_row_reg <= 8'(win_y_reg)) ? (y_end[7:0] - 8'd1)
                                                      : (cursor_row_reg - 8'd1);
        adv_x = cursor_col_reg;
        adv_y = cursor_row_reg;
        unique case (scan_mode_reg)
            SCAN_XP_YP:
            begin
                adv_x = x_fwd;
                adv_y = x_wrap_up ? y_fwd : cursor_row_reg;
            end
            SCAN_XP_YM:
            begin
                adv_x = x_fwd;
                adv_y = x_wrap_up ? y_back : cursor_row_reg;
            end
            SCAN_XM_YM:
            begin
                adv_x = x_back;
                adv_y = x_wrap_dn ? y_back : cursor_row_reg;
            end
            SCAN_XM_YP:
            begin
                adv_x = x_back;
                adv_y = x_wrap_dn ? y_fwd : cursor_row_reg;
            end
            SCAN_XP: adv_x = x_fwd;
            SCAN_YP: adv_y = y_fwd;
            default: ;
        endcase
    end

    // ---- page store ----
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_cnt_reg] <= 8'd0;
        end
        else if (land)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear && (clr_cnt_reg != LAST_ADDR))
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign sts.clear_last = (clr_cnt_reg == LAST_ADDR);

    // ---- request and result ----
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.commit)
            begin
                case (req_reg.req_type)
                    REQ_SET, REQ_READ:
                    begin
                        cursor_col_reg <= req_reg.pos_x;
                        cursor_row_reg <= req_reg.pos_y;
                    end
                    REQ_WRITE:
                    begin
                        cursor_col_reg <= adv_x;
                        cursor_row_reg <= adv_y;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg.written   <= land;
            result_reg.pixel_out <= (req_reg.req_type == REQ_READ) && on_panel &&
                                    rdata_reg[look_y[2:0]];
            case (req_reg.req_type)
                REQ_SET, REQ_READ:
                begin
                    result_reg.cur_x <= req_reg.pos_x;
                    result_reg.cur_y <= req_reg.pos_y;
                end
                REQ_WRITE:
                begin
                    result_reg.cur_x <= adv_x;
                    result_reg.cur_y <= adv_y;
                end
                default:
                begin
                    result_reg.cur_x <= cursor_col_reg;
                    result_reg.cur_y <= cursor_row_reg;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_written_only_write: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.written) |-> $past(req_reg.req_type == REQ_WRITE))
        else $error("written flagged on a non-write item");

    a_pixel_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.pixel_out) |-> $past(req_reg.req_type == REQ_READ))
        else $error("pixel_out set on a non-read item");

    a_no_store_write_on_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |-> !land)
        else $error("store written during lookup");

endmodule
`default_nettype wire
